### design/kmhid_pkg.sv
// Shared constants, types and control interfaces of the key matrix to HID report encoder.
`default_nettype none

package kmhid_pkg;

    // Sizing
    localparam int KEY_COUNT    = 44;
    localparam int LAYER_COUNT  = 5;
    localparam int SLOT_COUNT   = 6;

    localparam int KEY_W        = $clog2(KEY_COUNT);
    localparam int KEYMAP_DEPTH = LAYER_COUNT * KEY_COUNT;
    localparam int KEYMAP_AW    = $clog2(KEYMAP_DEPTH);

    // Fixed field widths
    localparam int OP_W      = 2;
    localparam int POS_W     = 6;
    localparam int LAYER_W   = 3;
    localparam int CODE_W    = 8;
    localparam int TRIG_W    = 15;
    localparam int ATTR_W    = TRIG_W + 1;
    localparam int SEL_W     = 3;
    localparam int FN_COUNT  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int SLOT_NUM  = 6;
    localparam int SLOT_IW   = $clog2(SLOT_NUM);

    // Function key reset positions
    localparam logic [POS_W-1:0] FN1_RESET = 6'd31;
    localparam logic [POS_W-1:0] FN2_RESET = 6'd32;
    localparam logic [POS_W-1:0] FN3_RESET = 6'd42;
    localparam logic [POS_W-1:0] FN4_RESET = 6'd43;

    // Report codes
    localparam logic [CODE_W-1:0] MOD_RCTRL  = 8'h10;
    localparam logic [CODE_W-1:0] MOD_RSHIFT = 8'h20;
    localparam logic [CODE_W-1:0] MOD_RALT   = 8'h40;
    localparam logic [CODE_W-1:0] CODE_NONE  = 8'h00;
    localparam logic [CODE_W-1:0] CODE_OVF   = 8'h01;

    // Trigger word layout: per fn key f, shift at 2f, altgr at 2f+1, ctrl at TRIG_FN_CTRL+f
    localparam int TRIG_KEY_SHIFT = 8;
    localparam int TRIG_KEY_ALT   = 9;
    localparam int TRIG_KEY_CTRL  = 10;
    localparam int TRIG_FN_CTRL   = 11;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_MAP  = 2'd0,
        OP_LOAD_ATTR = 2'd1,
        OP_SCAN      = 2'd2,
        OP_UNUSED    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FN1 = 2'd0,
        CFG_FN2 = 2'd1,
        CFG_FN3 = 2'd2,
        CFG_FN4 = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT
    } ctrl_state_t;

    typedef logic [SLOT_NUM-1:0][CODE_W-1:0] slots_t;

    typedef struct packed {
        logic start;
        logic step;
        logic load_map;
        logic load_attr;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        logic last_key;
        logic busy;
        logic emit_needed;
    } dp_status_t;

endpackage

`default_nettype wire

### design/kmhid_ram.sv
// Generic single write port RAM with one registered read port.
`default_nettype none

module kmhid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/kmhid_ctrl.sv
// Controller: sequences loads, the key walk and report hand-off.
`default_nettype none

module kmhid_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [kmhid_pkg::OP_W-1:0]     s_operation,
    output logic                           m_valid,
    input  logic                           m_ready,
    output kmhid_pkg::dp_cmd_t             cmd,
    input  kmhid_pkg::dp_status_t          status
);

    kmhid_pkg::ctrl_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kmhid_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            kmhid_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_operation)
                        kmhid_pkg::OP_SCAN: begin
                            cmd.start  = 1'b1;
                            state_next = kmhid_pkg::ST_WALK;
                        end
                        kmhid_pkg::OP_LOAD_MAP:  cmd.load_map  = 1'b1;
                        kmhid_pkg::OP_LOAD_ATTR: cmd.load_attr = 1'b1;
                        default: ;
                    endcase
                end
            end
            kmhid_pkg::ST_WALK: begin
                cmd.step = 1'b1;
                if (status.last_key) begin
                    state_next = kmhid_pkg::ST_DRAIN;
                end
            end
            kmhid_pkg::ST_DRAIN: begin
                if (!status.busy) begin
                    state_next = kmhid_pkg::ST_EMIT;
                end
            end
            kmhid_pkg::ST_EMIT: begin
                if (!status.emit_needed) begin
                    state_next = kmhid_pkg::ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    cmd.publish = 1'b1;
                    state_next  = kmhid_pkg::ST_IDLE;
                end
            end
            default: state_next = kmhid_pkg::ST_IDLE;
        endcase

        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### design/kmhid_datapath.sv
// Datapath: stores, function key registers, three-stage key walk and report registers.
`default_nettype none

module kmhid_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  kmhid_pkg::dp_cmd_t                   cmd,
    output kmhid_pkg::dp_status_t                status,
    input  logic                                 cfg_we,
    input  logic [kmhid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kmhid_pkg::POS_W-1:0]          cfg_wdata,
    input  logic [kmhid_pkg::POS_W-1:0]          s_key_position,
    input  logic [kmhid_pkg::LAYER_W-1:0]        s_layer,
    input  logic [kmhid_pkg::CODE_W-1:0]         s_keymap_code,
    input  logic                                 s_is_modifier_key,
    input  logic [kmhid_pkg::TRIG_W-1:0]         s_trigger_bits,
    input  logic [kmhid_pkg::KEY_COUNT-1:0]      s_pressed_keys,
    output logic [kmhid_pkg::CODE_W-1:0]         out_modifier,
    output kmhid_pkg::slots_t                    out_slots
);

    localparam int KW  = kmhid_pkg::KEY_W;
    localparam int PW  = kmhid_pkg::POS_W;
    localparam int CW  = kmhid_pkg::CODE_W;
    localparam int AMW = kmhid_pkg::KEYMAP_AW;

    // Function key positions
    logic [PW-1:0] fn_index_reg [kmhid_pkg::FN_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fn_index_reg[0] <= kmhid_pkg::FN1_RESET;
            fn_index_reg[1] <= kmhid_pkg::FN2_RESET;
            fn_index_reg[2] <= kmhid_pkg::FN3_RESET;
            fn_index_reg[3] <= kmhid_pkg::FN4_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                kmhid_pkg::CFG_FN1: fn_index_reg[0] <= cfg_wdata;
                kmhid_pkg::CFG_FN2: fn_index_reg[1] <= cfg_wdata;
                kmhid_pkg::CFG_FN3: fn_index_reg[2] <= cfg_wdata;
                kmhid_pkg::CFG_FN4: fn_index_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stores
    logic                          map_we, attr_we;
    logic [AMW-1:0]                map_waddr, map_raddr;
    logic [CW-1:0]                 map_rdata;
    logic [KW-1:0]                 attr_raddr;
    logic [kmhid_pkg::ATTR_W-1:0]  attr_rdata;
    logic                          pos_ok, layer_ok;

    assign pos_ok    = 32'(s_key_position) < kmhid_pkg::KEY_COUNT;
    assign layer_ok  = 32'(s_layer) < kmhid_pkg::LAYER_COUNT;
    assign map_we    = cmd.load_map && pos_ok && layer_ok;
    assign attr_we   = cmd.load_attr && pos_ok;
    assign map_waddr = AMW'(32'(s_layer) * kmhid_pkg::KEY_COUNT + 32'(s_key_position));

    kmhid_ram #(
        .WIDTH (CW),
        .DEPTH (kmhid_pkg::KEYMAP_DEPTH)
    ) u_keymap_ram (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (s_keymap_code),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    kmhid_ram #(
        .WIDTH (kmhid_pkg::ATTR_W),
        .DEPTH (kmhid_pkg::KEY_COUNT)
    ) u_attr_ram (
        .aclk  (aclk),
        .we    (attr_we),
        .waddr (s_key_position[KW-1:0]),
        .wdata ({s_is_modifier_key, s_trigger_bits}),
        .raddr (attr_raddr),
        .rdata (attr_rdata)
    );

    // Scan set-up: held function keys and selected layer
    logic [kmhid_pkg::KEY_COUNT-1:0] keys_reg;
    logic [kmhid_pkg::FN_COUNT-1:0]  fn_reg, fn_now;
    logic [kmhid_pkg::SEL_W-1:0]     sel_reg, sel_now;

    always_comb begin
        for (int f = 0; f < kmhid_pkg::FN_COUNT; f++) begin
            fn_now[f] = (32'(fn_index_reg[f]) < kmhid_pkg::KEY_COUNT)
                        && s_pressed_keys[fn_index_reg[f][KW-1:0]];
        end
        sel_now = '0;
        for (int f = kmhid_pkg::FN_COUNT - 1; f >= 0; f--) begin
            if (fn_now[f]) begin
                sel_now = kmhid_pkg::SEL_W'(f + 1);
            end
        end
        if (32'(sel_now) >= kmhid_pkg::LAYER_COUNT) begin
            sel_now = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            keys_reg <= s_pressed_keys;
            fn_reg   <= fn_now;
            sel_reg  <= sel_now;
        end
    end

    // Walk: A issues attribute read, B issues keymap read, C folds into the report
    logic [KW-1:0]                idx_reg, idx_b_reg, idx_c_reg;
    logic                         valid_b_reg, valid_c_reg;
    logic [kmhid_pkg::ATTR_W-1:0] attr_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                idx_reg <= '0;
            end else if (cmd.step) begin
                idx_reg <= idx_reg + 1'b1;
            end
            valid_b_reg <= cmd.step;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        idx_b_reg  <= idx_reg;
        idx_c_reg  <= idx_b_reg;
        attr_c_reg <= attr_rdata;
    end

    assign attr_raddr = idx_reg;
    // modifier keys always read the base layer
    assign map_raddr  = attr_rdata[kmhid_pkg::ATTR_W-1]
                      ? AMW'(idx_b_reg)
                      : AMW'(32'(sel_reg) * kmhid_pkg::KEY_COUNT + 32'(idx_b_reg));

    // Report accumulation
    logic [CW-1:0]         mod_reg, mod_next;
    kmhid_pkg::slots_t     slot_reg, slot_next;
    logic                  ovf_reg, ovf_next;
    logic                  ord_reg, ord_next;
    logic                  pressed_c, flag_c, is_fn_c, any_fn;
    logic                  alt_c, shf_c, ctl_c, free_found;
    logic [kmhid_pkg::TRIG_W-1:0] trig_c;
    logic [kmhid_pkg::SLOT_IW-1:0] free_slot;

    always_comb begin
        pressed_c = keys_reg[idx_c_reg];
        flag_c    = attr_c_reg[kmhid_pkg::ATTR_W-1];
        trig_c    = attr_c_reg[kmhid_pkg::TRIG_W-1:0];
        any_fn    = |fn_reg;

        is_fn_c = 1'b0;
        for (int f = 0; f < kmhid_pkg::FN_COUNT; f++) begin
            if (fn_index_reg[f] == PW'(idx_c_reg)) begin
                is_fn_c = 1'b1;
            end
        end

        alt_c = trig_c[kmhid_pkg::TRIG_KEY_ALT] && !any_fn;
        shf_c = trig_c[kmhid_pkg::TRIG_KEY_SHIFT] && !any_fn;
        ctl_c = trig_c[kmhid_pkg::TRIG_KEY_CTRL] && !any_fn;
        for (int f = 0; f < kmhid_pkg::FN_COUNT; f++) begin
            if (fn_reg[f]) begin
                alt_c = alt_c | trig_c[2*f+1];
                shf_c = shf_c | trig_c[2*f];
                ctl_c = ctl_c | trig_c[kmhid_pkg::TRIG_FN_CTRL+f];
            end
        end

        free_found = 1'b0;
        free_slot  = '0;
        for (int s = kmhid_pkg::SLOT_COUNT - 1; s >= 0; s--) begin
            if (slot_reg[s] == kmhid_pkg::CODE_NONE) begin
                free_found = 1'b1;
                free_slot  = kmhid_pkg::SLOT_IW'(s);
            end
        end

        mod_next  = mod_reg;
        slot_next = slot_reg;
        ovf_next  = ovf_reg;
        ord_next  = ord_reg;

        if (cmd.start) begin
            mod_next  = kmhid_pkg::CODE_NONE;
            slot_next = '0;
            ovf_next  = 1'b0;
            ord_next  = 1'b0;
        end else if (valid_c_reg && pressed_c) begin
            if (flag_c) begin
                mod_next = mod_reg | map_rdata;
            end else if (!is_fn_c) begin
                ord_next = 1'b1;
                if (!ovf_reg) begin
                    if (alt_c) begin
                        mod_next = mod_reg | kmhid_pkg::MOD_RALT;
                    end else if (shf_c) begin
                        mod_next = mod_reg | kmhid_pkg::MOD_RSHIFT;
                    end else if (ctl_c) begin
                        mod_next = mod_reg | kmhid_pkg::MOD_RCTRL;
                    end
                    if (free_found) begin
                        slot_next[free_slot] = map_rdata;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        mod_reg  <= mod_next;
        slot_reg <= slot_next;
        ovf_reg  <= ovf_next;
        ord_reg  <= ord_next;
    end

    // Output words and sent flag
    logic                 was_sent_reg;
    logic [CW-1:0]        out_mod_reg;
    kmhid_pkg::slots_t    out_slots_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_sent_reg <= 1'b0;
        end else if (cmd.publish) begin
            was_sent_reg <= ord_reg;
        end
    end

    // nothing ordinary seen: this is the empty report after a release
    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            if (!ord_reg) begin
                out_mod_reg   <= kmhid_pkg::CODE_NONE;
                out_slots_reg <= '0;
            end else begin
                out_mod_reg <= ovf_reg ? kmhid_pkg::CODE_OVF : mod_reg;
                for (int s = 0; s < kmhid_pkg::SLOT_NUM; s++) begin
                    out_slots_reg[s] <= ovf_reg ? kmhid_pkg::CODE_OVF : slot_reg[s];
                end
            end
        end
    end

    assign out_modifier       = out_mod_reg;
    assign out_slots          = out_slots_reg;
    assign status.last_key    = idx_reg == KW'(kmhid_pkg::KEY_COUNT - 1);
    assign status.busy        = valid_b_reg | valid_c_reg;
    assign status.emit_needed = ord_reg | was_sent_reg;

endmodule

`default_nettype wire

### design/keymatrix_to_hid_report_encoder_top.sv
// Top level of the key matrix to HID boot keyboard report encoder.
// Keymap and attribute loads are taken while idle and the input is ready again on the next
// cycle. A scan word holds off the input from acceptance through one walk step per key,
// the drain of the walk pipeline and the hand-over of the report. The walk reads one key
// per cycle through the attribute RAM and then the keymap RAM, both with registered read
// ports, so three stages are in flight and drain after the last key. The report leaves
// through an output register; a scan that finishes while the previous report is still
// unaccepted waits for it. The stores need no clearing after reset; entries not yet
// written read as garbage.
`default_nettype none

module keymatrix_to_hid_report_encoder_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [kmhid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kmhid_pkg::POS_W-1:0]          cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [kmhid_pkg::OP_W-1:0]           s_operation,
    input  logic [kmhid_pkg::POS_W-1:0]          s_key_position,
    input  logic [kmhid_pkg::LAYER_W-1:0]        s_layer,
    input  logic [kmhid_pkg::CODE_W-1:0]         s_keymap_code,
    input  logic                                 s_is_modifier_key,
    input  logic [kmhid_pkg::TRIG_W-1:0]         s_trigger_bits,
    input  logic [kmhid_pkg::KEY_COUNT-1:0]      s_pressed_keys,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [kmhid_pkg::CODE_W-1:0]         m_modifier_byte,
    output logic [kmhid_pkg::CODE_W-1:0]         m_slot1_code,
    output logic [kmhid_pkg::CODE_W-1:0]         m_slot2_code,
    output logic [kmhid_pkg::CODE_W-1:0]         m_slot3_code,
    output logic [kmhid_pkg::CODE_W-1:0]         m_slot4_code,
    output logic [kmhid_pkg::CODE_W-1:0]         m_slot5_code,
    output logic [kmhid_pkg::CODE_W-1:0]         m_slot6_code
);

    kmhid_pkg::dp_cmd_t    cmd;
    kmhid_pkg::dp_status_t status;
    kmhid_pkg::slots_t     slots;

    kmhid_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status)
    );

    kmhid_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_key_position    (s_key_position),
        .s_layer           (s_layer),
        .s_keymap_code     (s_keymap_code),
        .s_is_modifier_key (s_is_modifier_key),
        .s_trigger_bits    (s_trigger_bits),
        .s_pressed_keys    (s_pressed_keys),
        .out_modifier      (m_modifier_byte),
        .out_slots         (slots)
    );

    assign m_slot1_code = slots[0];
    assign m_slot2_code = slots[1];
    assign m_slot3_code = slots[2];
    assign m_slot4_code = slots[3];
    assign m_slot5_code = slots[4];
    assign m_slot6_code = slots[5];

endmodule

`default_nettype wire

### design/kmhid_checker.sv
// Port-level checker for the encoder top level, with its bind.
`default_nettype none

module kmhid_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [kmhid_pkg::OP_W-1:0]       s_operation,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [kmhid_pkg::CODE_W-1:0]     m_modifier_byte,
    input logic [kmhid_pkg::CODE_W-1:0]     m_slot1_code
);

    // nothing to deliver straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a scan word holds off the input while the walk runs
    a_scan_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation == kmhid_pkg::OP_SCAN) |=> !s_ready)
        else $error("input ready during scan walk");

    // loads finish in the cycle they are taken
    a_load_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && ((s_operation == kmhid_pkg::OP_LOAD_MAP)
                            || (s_operation == kmhid_pkg::OP_LOAD_ATTR)) |=> s_ready)
        else $error("load word stalled the input");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before accept");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_modifier_byte) && $stable(m_slot1_code))
        else $error("stalled result changed");

endmodule

bind keymatrix_to_hid_report_encoder_top kmhid_checker u_kmhid_checker (.*);

`default_nettype wire

### test/keymatrix_to_hid_report_encoder_top_tb.sv
// Self-checking testbench for the key matrix to HID boot keyboard report encoder.
module keymatrix_to_hid_report_encoder_top_tb;
    import kmhid_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = KEY_COUNT + 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_WORDS  = 220;
    localparam logic [KEY_COUNT-1:0] ONE_KEY = KEY_COUNT'(1);

    typedef struct {
        op_t                op;
        logic [POS_W-1:0]   pos;
        logic [LAYER_W-1:0] layer;
        logic [CODE_W-1:0]  code;
        logic               is_mod;
        logic [TRIG_W-1:0]  trig;
        logic [KEY_COUNT-1:0] keys;
    } key_word_t;

    typedef struct packed {
        logic [CODE_W-1:0] modifier;
        slots_t            slots;
    } hid_report_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FN1;
    logic [POS_W-1:0]     cfg_wdata = '0;

    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_operation       = '0;
    logic [POS_W-1:0]     s_key_position    = '0;
    logic [LAYER_W-1:0]   s_layer           = '0;
    logic [CODE_W-1:0]    s_keymap_code     = '0;
    logic                 s_is_modifier_key = 1'b0;
    logic [TRIG_W-1:0]    s_trigger_bits    = '0;
    logic [KEY_COUNT-1:0] s_pressed_keys    = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CODE_W-1:0] m_modifier_byte;
    logic [CODE_W-1:0] m_slot1_code;
    logic [CODE_W-1:0] m_slot2_code;
    logic [CODE_W-1:0] m_slot3_code;
    logic [CODE_W-1:0] m_slot4_code;
    logic [CODE_W-1:0] m_slot5_code;
    logic [CODE_W-1:0] m_slot6_code;

    // Shadow of the block's tables and function key layout
    logic [CODE_W-1:0] keymap_mem  [KEYMAP_DEPTH];
    logic [TRIG_W-1:0] trig_mem    [KEY_COUNT];
    logic              modflag_mem [KEY_COUNT];
    logic [POS_W-1:0]  fn_pos      [FN_COUNT] = '{FN1_RESET, FN2_RESET, FN3_RESET, FN4_RESET};
    logic              report_sent = 1'b0;

    hid_report_t pending_reports[$];

    logic idle_gaps = 1'b1;
    int   hold_reqs = 0;

    int err_count       = 0;
    int cycle_count     = 0;
    int scans_sent      = 0;
    int loads_sent      = 0;
    int ignored_sent    = 0;
    int reports_checked = 0;
    int rollover_count  = 0;
    int release_count   = 0;

    keymatrix_to_hid_report_encoder_top uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_key_position    (s_key_position),
        .s_layer           (s_layer),
        .s_keymap_code     (s_keymap_code),
        .s_is_modifier_key (s_is_modifier_key),
        .s_trigger_bits    (s_trigger_bits),
        .s_pressed_keys    (s_pressed_keys),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_modifier_byte   (m_modifier_byte),
        .m_slot1_code      (m_slot1_code),
        .m_slot2_code      (m_slot2_code),
        .m_slot3_code      (m_slot3_code),
        .m_slot4_code      (m_slot4_code),
        .m_slot5_code      (m_slot5_code),
        .m_slot6_code      (m_slot6_code)
    );

    always #6 aclk = ~aclk;

    function automatic bit fn_position(input int k);
        for (int f = 0; f < FN_COUNT; f++)
            if (fn_pos[f] == k) return 1'b1;
        return 1'b0;
    endfunction

    // Applies one accepted word to the shadow tables; returns 1 when a report is due
    function automatic bit predict_report(input key_word_t w, output hid_report_t rpt);
        logic [FN_COUNT-1:0] fn_down;
        logic [TRIG_W-1:0]   t;
        logic                any_fn, ordinary, overflow, alt, shf, ctl;
        int                  sel, s;
        rpt      = '0;
        ordinary = 1'b0;
        overflow = 1'b0;
        sel      = 0;
        if (w.op == OP_LOAD_MAP) begin
            if (w.pos < KEY_COUNT && w.layer < LAYER_COUNT)
                keymap_mem[w.layer * KEY_COUNT + w.pos] = w.code;
            return 1'b0;
        end
        if (w.op == OP_LOAD_ATTR) begin
            if (w.pos < KEY_COUNT) begin
                modflag_mem[w.pos] = w.is_mod;
                trig_mem[w.pos]    = w.trig;
            end
            return 1'b0;
        end
        if (w.op != OP_SCAN) return 1'b0;

        for (int f = 0; f < FN_COUNT; f++)
            fn_down[f] = (fn_pos[f] < KEY_COUNT) ? w.keys[fn_pos[f]] : 1'b0;
        any_fn = |fn_down;
        // lowest numbered held fn key wins
        for (int f = FN_COUNT - 1; f >= 0; f--)
            if (fn_down[f]) sel = f + 1;
        if (sel >= LAYER_COUNT) sel = 0;

        for (int k = 0; k < KEY_COUNT; k++)
            if (w.keys[k] && modflag_mem[k]) rpt.modifier |= keymap_mem[k];

        for (int k = 0; k < KEY_COUNT; k++) begin
            if (!w.keys[k] || modflag_mem[k] || fn_position(k)) continue;
            ordinary = 1'b1;
            if (overflow) continue;
            t   = trig_mem[k];
            alt = t[TRIG_KEY_ALT] && !any_fn;
            shf = t[TRIG_KEY_SHIFT] && !any_fn;
            ctl = t[TRIG_KEY_CTRL] && !any_fn;
            for (int f = 0; f < FN_COUNT; f++) begin
                if (fn_down[f]) begin
                    if (t[2 * f + 1]) alt = 1'b1;
                    if (t[2 * f]) shf = 1'b1;
                    if (t[TRIG_FN_CTRL + f]) ctl = 1'b1;
                end
            end
            if (alt) rpt.modifier |= MOD_RALT;
            else if (shf) rpt.modifier |= MOD_RSHIFT;
            else if (ctl) rpt.modifier |= MOD_RCTRL;

            s = 0;
            while (s < SLOT_COUNT && rpt.slots[s] != CODE_NONE) s++;
            if (s < SLOT_COUNT) begin
                rpt.slots[s] = keymap_mem[sel * KEY_COUNT + k];
            end else begin
                overflow     = 1'b1;
                rpt.modifier = CODE_OVF;
                for (int j = 0; j < SLOT_NUM; j++) rpt.slots[j] = CODE_OVF;
            end
        end

        if (ordinary) begin
            report_sent = 1'b1;
            if (overflow) rollover_count++;
            return 1'b1;
        end
        if (report_sent) begin
            rpt         = '0;
            report_sent = 1'b0;
            release_count++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_code(input string field, input logic [CODE_W-1:0] want,
                                       input logic [CODE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%02h, got 0x%02h", field, want, got);
            err_count++;
        end
    endfunction

    // every field random; callers overwrite what matters
    function automatic key_word_t noise_word();
        key_word_t   w;
        logic [63:0] wide;
        wide     = {$urandom, $urandom};
        w.op     = op_t'($urandom_range(3));
        w.pos    = POS_W'($urandom_range(63));
        w.layer  = LAYER_W'($urandom_range(7));
        w.code   = CODE_W'($urandom_range(255));
        w.is_mod = 1'($urandom_range(1));
        w.trig   = TRIG_W'($urandom_range(32767));
        w.keys   = wide[KEY_COUNT-1:0];
        return w;
    endfunction

    function automatic key_word_t map_load(input logic [POS_W-1:0] pos,
                                           input logic [LAYER_W-1:0] layer,
                                           input logic [CODE_W-1:0] code);
        key_word_t w;
        w       = noise_word();
        w.op    = OP_LOAD_MAP;
        w.pos   = pos;
        w.layer = layer;
        w.code  = code;
        return w;
    endfunction

    function automatic key_word_t attr_load(input logic [POS_W-1:0] pos, input logic is_mod,
                                            input logic [TRIG_W-1:0] trig);
        key_word_t w;
        w        = noise_word();
        w.op     = OP_LOAD_ATTR;
        w.pos    = pos;
        w.is_mod = is_mod;
        w.trig   = trig;
        return w;
    endfunction

    function automatic key_word_t scan_of(input logic [KEY_COUNT-1:0] keys);
        key_word_t w;
        w      = noise_word();
        w.op   = OP_SCAN;
        w.keys = keys;
        return w;
    endfunction

    // first ordinary keys with a non-zero base code
    function automatic logic [KEY_COUNT-1:0] pick_ordinary(input int wanted);
        logic [KEY_COUNT-1:0] mask;
        int                   got;
        mask = '0;
        got  = 0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (got < wanted && !modflag_mem[k] && !fn_position(k)
                && keymap_mem[k] != CODE_NONE) begin
                mask[k] = 1'b1;
                got++;
            end
        end
        return mask;
    endfunction

    function automatic logic [KEY_COUNT-1:0] random_keys();
        logic [KEY_COUNT-1:0] keys;
        logic [63:0]          wide;
        int                   roll;
        keys = '0;
        roll = $urandom_range(99);
        if (roll < 15) return keys;
        if (roll < 20) begin
            wide = {$urandom, $urandom};
            return wide[KEY_COUNT-1:0];
        end
        repeat ($urandom_range(1, 8)) keys[$urandom_range(KEY_COUNT - 1)] = 1'b1;
        for (int f = 0; f < FN_COUNT; f++)
            if (fn_pos[f] < KEY_COUNT && $urandom_range(3) == 0) keys[fn_pos[f]] = 1'b1;
        return keys;
    endfunction

    task automatic send_word(input key_word_t w);
        hid_report_t rpt;
        while (idle_gaps && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_operation       <= w.op;
        s_key_position    <= w.pos;
        s_layer           <= w.layer;
        s_keymap_code     <= w.code;
        s_is_modifier_key <= w.is_mod;
        s_trigger_bits    <= w.trig;
        s_pressed_keys    <= w.keys;
        s_valid           <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (predict_report(w, rpt)) pending_reports.push_back(rpt);
        case (w.op)
            OP_SCAN: scans_sent++;
            OP_LOAD_MAP, OP_LOAD_ATTR: loads_sent++;
            default: ignored_sent++;
        endcase
    endtask

    // sender pauses until every pending report is out and a scan with no report has finished
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_fn_keys(input logic [POS_W-1:0] p1, input logic [POS_W-1:0] p2,
                                 input logic [POS_W-1:0] p3, input logic [POS_W-1:0] p4);
        logic [POS_W-1:0] vals [FN_COUNT];
        vals[0] = p1;
        vals[1] = p2;
        vals[2] = p3;
        vals[3] = p4;
        for (int f = 0; f < FN_COUNT; f++) begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_idx_t'(f);
            cfg_wdata <= vals[f];
            @(posedge aclk);
            fn_pos[f] = vals[f];
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_words(input int count);
        key_word_t w;
        int        roll;
        repeat (count) begin
            w    = noise_word();
            roll = $urandom_range(99);
            if (roll < 85) begin
                w.op   = OP_SCAN;
                w.keys = random_keys();
            end else if (roll < 93) begin
                w.op     = (roll < 89) ? OP_LOAD_MAP : OP_LOAD_ATTR;
                w.pos    = POS_W'($urandom_range(KEY_COUNT - 1));
                w.layer  = LAYER_W'($urandom_range(LAYER_COUNT - 1));
                w.is_mod = ($urandom_range(99) < 18);
            end else if (roll < 97) begin
                w.op = (roll < 95) ? OP_LOAD_MAP : OP_LOAD_ATTR;
                if ($urandom_range(1)) w.pos = POS_W'($urandom_range(KEY_COUNT, 63));
                else w.layer = LAYER_W'($urandom_range(LAYER_COUNT, 7));
            end else begin
                w.op = OP_UNUSED;
            end
            send_word(w);
        end
    endtask

    // every keymap and attribute entry is written before any scan reads it
    task automatic test_fill_tables();
        for (int l = 0; l < LAYER_COUNT; l++)
            for (int k = 0; k < KEY_COUNT; k++)
                send_word(map_load(POS_W'(k), LAYER_W'(l),
                                   ($urandom_range(9) == 0) ? CODE_NONE
                                                            : CODE_W'($urandom_range(1, 255))));
        for (int k = 0; k < KEY_COUNT; k++)
            send_word(attr_load(POS_W'(k), $urandom_range(99) < 18,
                                TRIG_W'($urandom_range(32767))));
    endtask

    task automatic test_load_corners();
        key_word_t w;
        send_word(attr_load(6'd0, 1'b0, '0));
        send_word(map_load(6'd0, 3'd0, 8'hFF));
        send_word(map_load(6'd0, 3'd4, 8'h04));
        send_word(attr_load(6'd1, 1'b1, 15'h7FFF));
        send_word(map_load(6'd1, 3'd0, 8'h02));
        send_word(attr_load(6'd2, 1'b0,
                            TRIG_W'((1 << TRIG_KEY_ALT) | (1 << TRIG_KEY_SHIFT))));
        send_word(map_load(6'd2, 3'd0, CODE_NONE));
        // out of range loads must land nowhere
        send_word(map_load(6'd63, 3'd0, 8'h5A));
        send_word(map_load(6'd0, 3'd7, 8'h5A));
        send_word(map_load(6'd0, 3'd5, 8'h5A));
        send_word(attr_load(6'd44, 1'b1, 15'h7FFF));
        w    = noise_word();
        w.op = OP_UNUSED;
        send_word(w);
    endtask

    // fn keys still at their reset positions
    task automatic test_layer_select();
        send_word(scan_of('0));
        send_word(scan_of(ONE_KEY));
        send_word(scan_of(ONE_KEY | (ONE_KEY << 1) | (ONE_KEY << 2)));
        send_word(scan_of(ONE_KEY | (ONE_KEY << FN4_RESET)));
        send_word(scan_of(ONE_KEY | (ONE_KEY << FN1_RESET) | (ONE_KEY << FN4_RESET)));
        send_word(scan_of(ONE_KEY << 1));
        send_word(scan_of('0));
    endtask

    task automatic test_rollover();
        send_word(scan_of('1));
        send_word(scan_of('0));
        send_word(scan_of(pick_ordinary(6)));
        send_word(scan_of(pick_ordinary(7)));
        // a zero-code key takes no slot, so six others still fit
        send_word(scan_of(pick_ordinary(6) | (ONE_KEY << 2)));
        send_word(scan_of('0));
    endtask

    task automatic test_random_fn_layout();
        wait_drained();
        write_fn_keys(POS_W'($urandom_range(KEY_COUNT - 1)),
                      POS_W'($urandom_range(KEY_COUNT - 1)),
                      POS_W'($urandom_range(KEY_COUNT - 1)),
                      POS_W'($urandom_range(KEY_COUNT - 1)));
        run_random_words(PHASE_WORDS);
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        write_fn_keys(6'd0, POS_W'(KEY_COUNT - 1), 6'd1, 6'd63);
        hold_reqs++;
        run_random_words(PHASE_WORDS);
    endtask

    // no fn key reachable, and neither side idles
    task automatic test_unbroken_burst();
        wait_drained();
        write_fn_keys(6'd63, 6'd63, 6'd63, 6'd63);
        idle_gaps <= 1'b0;
        run_random_words(PHASE_WORDS);
        idle_gaps <= 1'b1;
    endtask

    task automatic test_reset_layout_restored();
        wait_drained();
        write_fn_keys(FN1_RESET, FN2_RESET, FN3_RESET, FN4_RESET);
        run_random_words(PHASE_WORDS);
    endtask

    initial begin : sink_ready
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(idle_gaps && $urandom_range(99) < 9);
            end
        end
    end

    always @(posedge aclk) begin : report_check
        hid_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected report: modifier_byte 0x%02h", m_modifier_byte);
                err_count++;
            end else begin
                want = pending_reports.pop_front();
                check_code("modifier_byte", want.modifier, m_modifier_byte);
                check_code("slot1_code", want.slots[0], m_slot1_code);
                check_code("slot2_code", want.slots[1], m_slot2_code);
                check_code("slot3_code", want.slots[2], m_slot3_code);
                check_code("slot4_code", want.slots[3], m_slot4_code);
                check_code("slot5_code", want.slots[4], m_slot5_code);
                check_code("slot6_code", want.slots[5], m_slot6_code);
                reports_checked++;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("watchdog: no finish within %0d cycles", CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : run
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_fill_tables();
        test_load_corners();
        test_layer_select();
        test_rollover();
        test_random_fn_layout();
        test_output_backpressure();
        test_unbroken_burst();
        test_random_fn_layout();
        test_reset_layout_restored();
        wait_drained();
        $display("Sent %0d scans, %0d table loads and %0d unused-op words over six fn layouts;",
                 scans_sent, loads_sent, ignored_sent);
        $display("checked %0d reports, %0d rollover and %0d key-release.",
                 reports_checked, rollover_count, release_count);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
design/kmhid_pkg.sv
design/kmhid_ram.sv
design/kmhid_ctrl.sv
design/kmhid_datapath.sv
design/keymatrix_to_hid_report_encoder_top.sv
design/kmhid_checker.sv
test/keymatrix_to_hid_report_encoder_top_tb.sv
